// ----- hw/rtl/turing_machine_step_engine_assert.svh -----
// Assertion macros shared by the step engine's checker.
`ifndef TURING_MACHINE_STEP_ENGINE_ASSERT_SVH
`define TURING_MACHINE_STEP_ENGINE_ASSERT_SVH

// Property checked on every rising clock edge, off while reset is high.
`define TME_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TME_ASSERT_NEXT(label, ante, cons, msg) \
   `TME_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/tme_pkg.sv -----
// Shared types, codes and constants of the Turing machine step engine.
`default_nettype none

package tme_pkg;

   localparam int STATE_COUNT_DEF = 1024;
   localparam int TAPE_DEPTH_DEF  = 65536;

   localparam int STATE_W = 10;
   localparam int ADDR_W  = 16;
   localparam int STEP_W  = 40;
   localparam int CSR_IDX_W = 1;

   localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 40'd1048576;
   localparam logic [ADDR_W-1:0] ORIGIN_RESET     = 16'd32768;

   // operation codes
   localparam logic [2:0] OP_LOAD_RULE = 3'd0;
   localparam logic [2:0] OP_LOAD_CELL = 3'd1;
   localparam logic [2:0] OP_STEP      = 3'd2;
   localparam logic [2:0] OP_READ_CELL = 3'd3;
   localparam logic [2:0] OP_RESTART   = 3'd4;

   // rule moves
   localparam logic [1:0] MOVE_STOP  = 2'd0;
   localparam logic [1:0] MOVE_RIGHT = 2'd1;
   localparam logic [1:0] MOVE_LEFT  = 2'd2;

   // result status
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_LIMIT    = 2'd1;
   localparam logic [1:0] STATUS_OFF_TAPE = 2'd2;
   localparam logic [1:0] STATUS_HALTED   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_ORIGIN = 1'b1;

   typedef struct packed {
      logic [2:0]         operation;
      logic [STATE_W-1:0] rule_state;
      logic               rule_read;
      logic               rule_write;
      logic [1:0]         rule_move;
      logic [STATE_W-1:0] rule_next;
      logic [ADDR_W-1:0]  cell_address;
      logic               cell_value;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] machine_state;
      logic               symbol_read;
      logic               symbol_written;
      logic [ADDR_W-1:0]  head_position;
      logic               halted;
      logic [1:0]         status;
      logic [STEP_W-1:0]  steps_taken;
      logic               cell_data;
   } rsp_type;

   typedef struct packed {
      logic               write_bit;
      logic [1:0]         move;
      logic [STATE_W-1:0] goto_state;
   } rule_type;

   // one memory port's strobes
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_TAPE,
      SEQ_RULE
   } seq_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tme_tape_mem.sv -----
// Tape memory: one bit per cell, one port, clearing sweep after reset.
`default_nettype none

module tme_tape_mem #(
   parameter int TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tme_pkg::mem_ctl_type          ctl,
   input  logic [$clog2(TAPE_DEPTH)-1:0] addr,
   input  logic                          wdata,
   output logic                          q,
   output logic                          clearing
);
   import tme_pkg::*;

   localparam int TAPE_AW = $clog2(TAPE_DEPTH);

   logic                mem [TAPE_DEPTH];
   logic                q_ff;
   logic [TAPE_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                clearing_ff, clearing_in;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == TAPE_AW'(TAPE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= 1'b0;
      end else if (ctl.wr) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd) begin
         q_ff <= mem[addr];
      end
   end

   assign q        = q_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tme_rule_mem.sv -----
// Rule table memory: (state, read bit) -> write bit, move, next state.
`default_nettype none

module tme_rule_mem #(
   parameter int STATE_COUNT = tme_pkg::STATE_COUNT_DEF
) (
   input  logic                         clock,
   input  tme_pkg::mem_ctl_type         ctl,
   input  logic [$clog2(STATE_COUNT):0] addr,
   input  tme_pkg::rule_type            wdata,
   output tme_pkg::rule_type            q
);
   import tme_pkg::*;

   localparam int RULE_DEPTH = 2 * STATE_COUNT;

   rule_type mem [RULE_DEPTH];
   rule_type q_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd) begin
         q_ff <= mem[addr];
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tme_seq.sv -----
// Item sequencer: tape read, rule read, tape or rule write and machine registers.
`default_nettype none

module tme_seq #(
   parameter int STATE_COUNT = tme_pkg::STATE_COUNT_DEF,
   parameter int TAPE_DEPTH  = tme_pkg::TAPE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tme_pkg::req_type              req_item,
   output logic                          rsp_strobe,
   output tme_pkg::rsp_type              rsp_item,
   input  logic [tme_pkg::STEP_W-1:0]    step_limit,
   input  logic [tme_pkg::ADDR_W-1:0]    head_origin,
   input  logic                          tape_clearing,
   output tme_pkg::mem_ctl_type          tape_ctl,
   output logic [$clog2(TAPE_DEPTH)-1:0] tape_addr,
   output logic                          tape_wdata,
   input  logic                          tape_q,
   output tme_pkg::mem_ctl_type          rule_ctl,
   output logic [$clog2(STATE_COUNT):0]  rule_addr,
   output tme_pkg::rule_type             rule_wdata,
   input  tme_pkg::rule_type             rule_q
);
   import tme_pkg::*;

   localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
   localparam int STATE_AW = $clog2(STATE_COUNT);
   localparam int HEAD_W   = (TAPE_AW > ADDR_W) ? TAPE_AW : ADDR_W;

   seq_state_type       seq_state_ff, seq_state_in;
   req_type             item_ff, item_in;
   rsp_type             rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;
   logic [STATE_W-1:0]  cur_state_ff, cur_state_in;
   logic [HEAD_W-1:0]   head_ff, head_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic                halt_ff, halt_in;

   logic                accept;
   logic                head_on_tape;
   logic                head_at_right;
   logic                state_in_table;
   logic                rule_slot_ok;
   logic                cell_ok;
   rule_type            entry;

   assign busy   = tape_clearing || (seq_state_ff != SEQ_IDLE);
   assign accept = start && !busy;

   assign head_on_tape   = 33'(head_ff) < 33'(TAPE_DEPTH);
   assign head_at_right  = (33'(head_ff) + 33'd1) >= 33'(TAPE_DEPTH);
   assign state_in_table = 17'(cur_state_ff) < 17'(STATE_COUNT);
   assign rule_slot_ok   = 17'(item_ff.rule_state) < 17'(STATE_COUNT);
   assign cell_ok        = 33'(item_ff.cell_address) < 33'(TAPE_DEPTH);
   assign entry          = state_in_table ? rule_q : '0;

   // next state
   always_comb begin
      case (seq_state_ff)
         SEQ_IDLE: seq_state_in = accept ? SEQ_TAPE : SEQ_IDLE;
         SEQ_TAPE: seq_state_in = SEQ_RULE;
         SEQ_RULE: seq_state_in = SEQ_IDLE;
         default:  seq_state_in = SEQ_IDLE;
      endcase
   end

   // outputs and register updates
   always_comb begin
      item_in      = item_ff;
      cur_state_in = cur_state_ff;
      head_in      = head_ff;
      steps_in     = steps_ff;
      halt_in      = halt_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      tape_ctl     = '0;
      tape_addr    = TAPE_AW'(head_ff);
      tape_wdata   = 1'b0;
      rule_ctl     = '0;
      rule_addr    = {STATE_AW'(cur_state_ff), tape_q};
      rule_wdata   = '{write_bit:  item_ff.rule_write,
                       move:       item_ff.rule_move,
                       goto_state: item_ff.rule_next};

      case (seq_state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               item_in     = req_item;
               tape_ctl.rd = 1'b1;
               if (req_item.operation != OP_STEP) begin
                  tape_addr = TAPE_AW'(req_item.cell_address);
               end
            end
         end
         SEQ_TAPE: begin
            rule_ctl.rd = 1'b1;
         end
         SEQ_RULE: begin
            strobe_in                = 1'b1;
            rsp_in                   = '0;
            rsp_in.machine_state     = cur_state_ff;
            case (item_ff.operation)
               OP_LOAD_RULE: begin
                  rule_addr   = {STATE_AW'(item_ff.rule_state), item_ff.rule_read};
                  rule_ctl.wr = rule_slot_ok;
               end
               OP_LOAD_CELL: begin
                  tape_addr   = TAPE_AW'(item_ff.cell_address);
                  tape_wdata  = item_ff.cell_value;
                  tape_ctl.wr = cell_ok;
               end
               OP_STEP: begin
                  if (halt_ff) begin
                     rsp_in.status = STATUS_HALTED;
                  end else if (steps_ff >= step_limit) begin
                     halt_in       = 1'b1;
                     rsp_in.status = STATUS_LIMIT;
                  end else if (!head_on_tape) begin
                     halt_in       = 1'b1;
                     rsp_in.status = STATUS_OFF_TAPE;
                  end else begin
                     rsp_in.symbol_read    = tape_q;
                     rsp_in.symbol_written = entry.write_bit;
                     tape_wdata            = entry.write_bit;
                     tape_ctl.wr           = 1'b1;
                     steps_in              = steps_ff + 1'b1;
                     case (entry.move)
                        MOVE_RIGHT: begin
                           if (head_at_right) begin
                              halt_in       = 1'b1;
                              rsp_in.status = STATUS_OFF_TAPE;
                           end else begin
                              head_in      = head_ff + 1'b1;
                              cur_state_in = entry.goto_state;
                           end
                        end
                        MOVE_LEFT: begin
                           if (head_ff == '0) begin
                              halt_in       = 1'b1;
                              rsp_in.status = STATUS_OFF_TAPE;
                           end else begin
                              head_in      = head_ff - 1'b1;
                              cur_state_in = entry.goto_state;
                           end
                        end
                        default: halt_in = 1'b1;   // stop, and move code three
                     endcase
                  end
               end
               OP_READ_CELL: begin
                  rsp_in.cell_data = cell_ok && tape_q;
               end
               OP_RESTART: begin
                  cur_state_in         = '0;
                  head_in              = HEAD_W'(head_origin);
                  steps_in             = '0;
                  halt_in              = 1'b0;
                  rsp_in.machine_state = '0;
               end
               default: ;
            endcase
            rsp_in.head_position = ADDR_W'(head_in);
            rsp_in.halted        = halt_in;
            rsp_in.steps_taken   = steps_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= SEQ_IDLE;
         strobe_ff    <= 1'b0;
         cur_state_ff <= '0;
         head_ff      <= HEAD_W'(ORIGIN_RESET);
         steps_ff     <= '0;
         halt_ff      <= 1'b0;
      end else begin
         seq_state_ff <= seq_state_in;
         strobe_ff    <= strobe_in;
         cur_state_ff <= cur_state_in;
         head_ff      <= head_in;
         steps_ff     <= steps_in;
         halt_ff      <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/turing_machine_step_engine.sv -----
// Top level of the two-symbol Turing machine step engine.
`default_nettype none

// Usage:
//  - Command channel: an item (req_item) is taken on a rising edge with start
//    high and busy low. Operations: load rule, load cell, step, read cell,
//    restart; codes outside that list only report the current state.
//  - Result channel: every item gives exactly one result beat, shown on
//    rsp_item for one cycle with rsp_strobe high. There is no back-pressure;
//    the receiver must take the beat in that cycle.
//  - Sequencing: the accepted item passes the tape read and rule read states;
//    the result beat is registered as it goes back to idle, and busy drops in
//    the same cycle. The order is set by the step's dependent memory chain:
//    tape read, then rule table read at (state, symbol), then tape write-back.
//    Every item takes the same path. Items never overlap, which is the
//    interlock between the write-back and the next tape read.
//  - Reset (synchronous, active high): machine in state 0, head at 32768,
//    step count 0, not halted, registers back to their defaults. The tape is
//    then cleared one cell a cycle, and busy stays high until the sweep has
//    reached the last cell. The rule table is not cleared; load every rule
//    a program can reach before stepping.
//  - CSR port: csr_we writes csr_wdata to register csr_index at once
//    (0 step limit, 1 head origin). Write only while no item is in flight.

module turing_machine_step_engine #(
   parameter int STATE_COUNT = tme_pkg::STATE_COUNT_DEF,
   parameter int TAPE_DEPTH  = tme_pkg::TAPE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tme_pkg::req_type                req_item,
   output logic                            rsp_strobe,
   output tme_pkg::rsp_type                rsp_item,
   input  logic                            csr_we,
   input  logic [tme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tme_pkg::STEP_W-1:0]      csr_wdata
);
   import tme_pkg::*;

   localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
   localparam int STATE_AW = $clog2(STATE_COUNT);

   // configuration registers
   logic [STEP_W-1:0]  step_limit_ff, step_limit_in;
   logic [ADDR_W-1:0]  head_origin_ff, head_origin_in;

   // memory ports
   mem_ctl_type         tape_ctl;
   logic [TAPE_AW-1:0]  tape_addr;
   logic                tape_wdata;
   logic                tape_q;
   logic                tape_clearing;
   mem_ctl_type         rule_ctl;
   logic [STATE_AW:0]   rule_addr;
   rule_type            rule_wdata;
   rule_type            rule_q;

   always_comb begin
      step_limit_in  = step_limit_ff;
      head_origin_in = head_origin_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEP_LIMIT:  step_limit_in  = csr_wdata;
            CSR_HEAD_ORIGIN: head_origin_in = csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff  <= STEP_LIMIT_RESET;
         head_origin_ff <= ORIGIN_RESET;
      end else begin
         step_limit_ff  <= step_limit_in;
         head_origin_ff <= head_origin_in;
      end
   end

   tme_seq #(
      .STATE_COUNT (STATE_COUNT),
      .TAPE_DEPTH  (TAPE_DEPTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .step_limit    (step_limit_ff),
      .head_origin   (head_origin_ff),
      .tape_clearing (tape_clearing),
      .tape_ctl      (tape_ctl),
      .tape_addr     (tape_addr),
      .tape_wdata    (tape_wdata),
      .tape_q        (tape_q),
      .rule_ctl      (rule_ctl),
      .rule_addr     (rule_addr),
      .rule_wdata    (rule_wdata),
      .rule_q        (rule_q)
   );

   tme_tape_mem #(
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tape_ctl),
      .addr     (tape_addr),
      .wdata    (tape_wdata),
      .q        (tape_q),
      .clearing (tape_clearing)
   );

   tme_rule_mem #(
      .STATE_COUNT (STATE_COUNT)
   ) u_rules (
      .clock (clock),
      .ctl   (rule_ctl),
      .addr  (rule_addr),
      .wdata (rule_wdata),
      .q     (rule_q)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/tme_checker.sv -----
// Port-level checker for the step engine, bound to the top level.
`default_nettype none

`include "turing_machine_step_engine_assert.svh"

module tme_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tme_pkg::req_type req_item,
   input logic             rsp_strobe,
   input tme_pkg::rsp_type rsp_item
);
   import tme_pkg::*;

   // every accepted item answers with a result beat
   `TME_ASSERT(a_fixed_latency, (start && !busy) |-> ##3 rsp_strobe, "result beat missing")

   // an item in flight holds off the next one
   `TME_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after accept")

   `TME_ASSERT_NEXT(a_single_beat, rsp_strobe, !rsp_strobe, "result beat repeated")

   // any error or halted status leaves the machine halted
   `TME_ASSERT(a_error_halts, (rsp_strobe && rsp_item.status != STATUS_OK) |-> rsp_item.halted, "error status without halt")

   // restart clears the step count and the halt flag
   `TME_ASSERT(a_restart_clears, (rsp_strobe && $past(start && !busy, 3) && ($past(req_item.operation, 3) == OP_RESTART) && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)) |-> (rsp_item.steps_taken == '0 && !rsp_item.halted), "restart left state behind")

endmodule

bind turing_machine_step_engine tme_checker u_checker (.*);

`default_nettype wire
